[design/rhsi_pkg.sv]
// ----------------------------------------------------------------------------
// rhsi_pkg
// Shared types and constants for the RGB to HSI converter.
// ----------------------------------------------------------------------------
package rhsi_pkg;

    localparam int COMP_W   = 8;
    localparam int FRAC_W   = 6;
    localparam int HUE_W    = 15;
    localparam int SAT_W    = 13;
    localparam int INT_W    = 14;
    localparam int ANG_FRAC = 20;
    localparam int STEPS    = 26;
    localparam int VEC_W    = 44;
    localparam int ZW       = 30;
    localparam int SUM_W    = COMP_W + 2;
    localparam int NUM_W    = SUM_W + 7 + FRAC_W + 1;
    localparam int QDEPTH   = 4;

    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

    typedef struct packed {
        logic             gray;
        logic             neg_x;
        logic             b_gt_g;
        logic [COMP_W:0]  xmag;
        logic [COMP_W-1:0] dmag;
        logic [SUM_W-1:0] sum;
        logic [COMP_W-1:0] mn;
    } item_t;

    typedef struct packed {
        logic             gray;
        logic             neg_x;
        logic             b_gt_g;
        logic [SUM_W-1:0] sum;
        logic [COMP_W-1:0] mn;
    } tag_t;

    function automatic logic [ZW-1:0] atan_deg(input logic [4:0] i);
        logic [ZW-1:0] v;
        begin
            unique case (i)
                5'd0: v = 30'd47185920;
                5'd1: v = 30'd27855475;
                5'd2: v = 30'd14718068;
                5'd3: v = 30'd7471121;
                5'd4: v = 30'd3750058;
                5'd5: v = 30'd1876857;
                5'd6: v = 30'd938658;
                5'd7: v = 30'd469357;
                5'd8: v = 30'd234682;
                5'd9: v = 30'd117342;
                5'd10: v = 30'd58671;
                5'd11: v = 30'd29335;
                5'd12: v = 30'd14668;
                5'd13: v = 30'd7334;
                5'd14: v = 30'd3667;
                5'd15: v = 30'd1833;
                5'd16: v = 30'd917;
                5'd17: v = 30'd458;
                5'd18: v = 30'd229;
                5'd19: v = 30'd115;
                5'd20: v = 30'd57;
                5'd21: v = 30'd29;
                5'd22: v = 30'd14;
                5'd23: v = 30'd7;
                5'd24: v = 30'd4;
                5'd25: v = 30'd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[design/rgb_to_hsi_converter.sv]
// Each request taken comes out with strobe after the front register, the queue,
// the back entry register, the 26 CORDIC stages and the output registers.
// Throughput one pixel per cycle.
// busy is never raised; the receiver cannot stall, so no request waits.
// Reset (rst_n, async low) clears all valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsi_converter
// Converts RGB pixels to hue, saturation and intensity in fixed point.
// ----------------------------------------------------------------------------
module rgb_to_hsi_converter
    import rhsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output logic              strobe,
    output logic [HUE_W-1:0]  hue,
    output logic [SAT_W-1:0]  saturation,
    output logic [INT_W-1:0]  intensity
);

    logic  f_valid;
    item_t f_item;
    logic  q_valid;
    item_t q_item;

    assign busy = 1'b0;

    rhsi_front u_front (
        .clk(clk), .rst_n(rst_n), .take(start && !busy),
        .red(red), .green(green), .blue(blue),
        .item_valid(f_valid), .item(f_item)
    );

    rhsi_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .din(f_item),
        .pop_valid(q_valid), .dout(q_item)
    );

    rhsi_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .item(q_item),
        .out_valid(strobe), .hue(hue), .saturation(saturation),
        .intensity(intensity)
    );

`ifndef SYNTHESIS
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> hue <= HUE_W'(360 << FRAC_W))
        else $error("hue out of range");
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> saturation <= SAT_W'(100 << FRAC_W))
        else $error("saturation out of range");
    a_front_follow: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> f_valid)
        else $error("request lost in front");
`endif

endmodule

[design/rhsi_front.sv]
// ----------------------------------------------------------------------------
// rhsi_front
// Accepts pixels and classifies them: gray test, chroma vector, sum, min.
// ----------------------------------------------------------------------------
module rhsi_front
    import rhsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    output logic              item_valid,
    output item_t             item
);

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic signed [COMP_W+2:0] xs;
    logic [COMP_W-1:0] m0;

    always_comb
    begin
        xs = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
             - $signed({3'b000, blue});
        m0 = (green < red) ? green : red;
        item_next.gray   = (red == green) && (green == blue);
        item_next.neg_x  = xs[COMP_W+2];
        item_next.b_gt_g = blue > green;
        item_next.xmag   = xs[COMP_W+2] ? COMP_W'(0) + (COMP_W+1)'(-xs)
                                        : (COMP_W+1)'(xs);
        item_next.dmag   = (blue > green) ? blue - green : green - blue;
        item_next.sum    = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
        item_next.mn     = (blue < m0) ? blue : m0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[design/rhsi_queue.sv]
// ----------------------------------------------------------------------------
// rhsi_queue
// Short FIFO between front and back; the back always drains it.
// ----------------------------------------------------------------------------
module rhsi_queue
    import rhsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t din,
    output logic  pop_valid,
    output item_t dout
);

    item_t mem [QDEPTH];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic       valid_reg;
    item_t      dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (cnt_reg != 3'd0)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg   <= cnt_reg + 3'(push) - 3'(cnt_reg != 3'd0);
            valid_reg <= cnt_reg != 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= din;
        dout_reg <= mem[rp_reg];
    end

    assign pop_valid = valid_reg;
    assign dout      = dout_reg;

endmodule

[design/rhsi_back.sv]
// ----------------------------------------------------------------------------
// rhsi_back
// Pipelined CORDIC for hue, plus saturation and intensity arithmetic.
// ----------------------------------------------------------------------------
module rhsi_back
    import rhsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  item_t             item,
    output logic              out_valid,
    output logic [HUE_W-1:0]  hue,
    output logic [SAT_W-1:0]  saturation,
    output logic [INT_W-1:0]  intensity
);

    localparam int NST    = STEPS + 1;
    localparam int DIV_AT = STEPS - SAT_W + 1;

    logic                    v_reg [NST];
    tag_t                    t_reg [NST];
    logic signed [VEC_W-1:0] x_reg [NST];
    logic signed [VEC_W-1:0] y_reg [NST];
    logic signed [ZW:0]      z_reg [NST];
    logic [NUM_W-1:0]        nr_reg [SAT_W-1];
    logic [SAT_W-1:0]        q_reg [SAT_W];

    logic signed [VEC_W-1:0] ax;
    logic signed [VEC_W-1:0] ay;
    logic [NUM_W-1:0] num0;
    logic [INT_W-1:0] int_reg;

    function automatic logic signed [VEC_W-1:0] shr_s(input logic signed [VEC_W-1:0] v,
                                                      input int s);
        return v[VEC_W-1] ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic logic [NUM_W-1:0] den_shift(input logic [SUM_W-1:0] s,
                                                   input int k);
        return NUM_W'({s, 1'b0}) << k;
    endfunction

    always_comb
    begin
        ax = $signed(VEC_W'(item.xmag) << 30);
        ay = $signed(VEC_W'(item.dmag) * VEC_W'(SQRT3_Q30));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int k = 0; k < NST; k++)
                v_reg[k] <= 1'b0;
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg[0] <= '{gray: item.gray, neg_x: item.neg_x, b_gt_g: item.b_gt_g,
                      sum: item.sum, mn: item.mn};
        for (int k = 1; k < NST; k++)
            t_reg[k] <= t_reg[k-1];
        if (item.neg_x)
        begin
            x_reg[0] <= ay;
            y_reg[0] <= ax;
        end
        else
        begin
            x_reg[0] <= ax;
            y_reg[0] <= ay;
        end
        z_reg[0] <= '0;
        for (int k = 0; k < STEPS; k++)
        begin
            if (!y_reg[k][VEC_W-1])
            begin
                x_reg[k+1] <= x_reg[k] + shr_s(y_reg[k], k);
                y_reg[k+1] <= y_reg[k] - shr_s(x_reg[k], k);
                z_reg[k+1] <= z_reg[k] + $signed({1'b0, atan_deg(5'(k))});
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] - shr_s(y_reg[k], k);
                y_reg[k+1] <= y_reg[k] + shr_s(x_reg[k], k);
                z_reg[k+1] <= z_reg[k] - $signed({1'b0, atan_deg(5'(k))});
            end
        end
    end

    // saturation: restoring divide, one quotient bit per stage, ends with the CORDIC
    always_comb
    begin
        num0 = NUM_W'(100 * 64 * 2) * NUM_W'(t_reg[DIV_AT-1].sum
               - SUM_W'(3 * t_reg[DIV_AT-1].mn)) + NUM_W'(t_reg[DIV_AT-1].sum);
    end

    always_ff @(posedge clk)
    begin
        if (num0 >= den_shift(t_reg[DIV_AT-1].sum, SAT_W - 1))
        begin
            nr_reg[0] <= num0 - den_shift(t_reg[DIV_AT-1].sum, SAT_W - 1);
            q_reg[0]  <= SAT_W'(1) << (SAT_W - 1);
        end
        else
        begin
            nr_reg[0] <= num0;
            q_reg[0]  <= '0;
        end
        for (int k = 1; k < SAT_W - 1; k++)
        begin
            if (nr_reg[k-1] >= den_shift(t_reg[DIV_AT+k-1].sum, SAT_W - 1 - k))
            begin
                nr_reg[k] <= nr_reg[k-1] - den_shift(t_reg[DIV_AT+k-1].sum, SAT_W - 1 - k);
                q_reg[k]  <= q_reg[k-1] | (SAT_W'(1) << (SAT_W - 1 - k));
            end
            else
            begin
                nr_reg[k] <= nr_reg[k-1];
                q_reg[k]  <= q_reg[k-1];
            end
        end
        q_reg[SAT_W-1] <= q_reg[SAT_W-2]
                          | SAT_W'(nr_reg[SAT_W-2] >= den_shift(t_reg[STEPS-1].sum, 0));
        int_reg <= INT_W'(((32'(t_reg[STEPS-1].sum) << 7) + 32'd3) * 32'd43691 >> 18);
    end

    logic signed [ZW+1:0] zc;
    logic [HUE_W-1:0] phi;
    logic [HUE_W-1:0] hue_reg;
    logic [SAT_W-1:0] sat_reg;
    logic [INT_W-1:0] inten_reg;
    logic             ov_reg;

    always_comb
    begin
        zc = t_reg[STEPS].neg_x ? ($signed({z_reg[STEPS][ZW], z_reg[STEPS]})
                                   + $signed(32'(90 << ANG_FRAC)))
                                : $signed({z_reg[STEPS][ZW], z_reg[STEPS]});
        if (zc < 0)
            zc = '0;
        if (zc > $signed(32'(180 << ANG_FRAC)))
            zc = $signed(32'(180 << ANG_FRAC));
        phi = HUE_W'((zc + 32'(1 << 13)) >>> 14);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= v_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (t_reg[STEPS].gray)
            hue_reg <= HUE_W'(90 << FRAC_W);
        else if (t_reg[STEPS].b_gt_g)
            hue_reg <= HUE_W'(360 << FRAC_W) - phi;
        else
            hue_reg <= phi;
        sat_reg   <= (t_reg[STEPS].sum == '0) ? SAT_W'(100 << FRAC_W) : q_reg[SAT_W-1];
        inten_reg <= int_reg;
    end

    assign out_valid  = ov_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign intensity  = inten_reg;

endmodule
